>>> sv/jrq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jrq_pkg
// Shared constants, types and the candidate ratio table of the quantizer.
// ----------------------------------------------------------------------------
package jrq_pkg;

  localparam int FRACTION_BITS_DEF = 16;
  localparam int INTEGER_BITS_DEF  = 8;

  // Candidate table size and index width
  localparam int NUM_CAND = 24;
  localparam int CIW      = 5;

  // Output field widths
  localparam int EXP_OUT_W = 6;
  localparam int NUM_OUT_W = 14;
  localparam int DEN_OUT_W = 24;

  // Pipeline control that travels with each beat
  typedef struct packed {
    logic valid;
    logic zero;
  } ctl_t;

  // One candidate: octave offset, odd factor, denominator 3 and 5 flags
  typedef struct packed {
    logic signed [3:0] off;
    logic [3:0]        odd;
    logic              by3;
    logic              by5;
  } cand_t;

  function automatic cand_t cand_lookup(input logic [CIW-1:0] idx);
    cand_t c;
    unique case (idx)
      5'd0:    c = '{off:  4'sd0, odd: 4'd1,  by3: 1'b0, by5: 1'b0};
      5'd1:    c = '{off: -4'sd1, odd: 4'd3,  by3: 1'b0, by5: 1'b0};
      5'd2:    c = '{off:  4'sd2, odd: 4'd1,  by3: 1'b1, by5: 1'b0};
      5'd3:    c = '{off:  4'sd0, odd: 4'd5,  by3: 1'b1, by5: 1'b0};
      5'd4:    c = '{off: -4'sd2, odd: 4'd5,  by3: 1'b0, by5: 1'b0};
      5'd5:    c = '{off:  4'sd1, odd: 4'd3,  by3: 1'b0, by5: 1'b1};
      5'd6:    c = '{off:  4'sd3, odd: 4'd1,  by3: 1'b0, by5: 1'b1};
      5'd7:    c = '{off: -4'sd2, odd: 4'd7,  by3: 1'b0, by5: 1'b0};
      5'd8:    c = '{off:  4'sd0, odd: 4'd7,  by3: 1'b0, by5: 1'b1};
      5'd9:    c = '{off:  4'sd0, odd: 4'd9,  by3: 1'b0, by5: 1'b1};
      5'd10:   c = '{off: -4'sd1, odd: 4'd7,  by3: 1'b1, by5: 1'b0};
      5'd11:   c = '{off: -4'sd1, odd: 4'd11, by3: 1'b1, by5: 1'b0};
      5'd12:   c = '{off:  4'sd1, odd: 4'd1,  by3: 1'b0, by5: 1'b0};
      5'd13:   c = '{off:  4'sd0, odd: 4'd3,  by3: 1'b0, by5: 1'b1};
      5'd14:   c = '{off: -4'sd3, odd: 4'd5,  by3: 1'b0, by5: 1'b0};
      5'd15:   c = '{off:  4'sd1, odd: 4'd1,  by3: 1'b1, by5: 1'b0};
      5'd16:   c = '{off: -4'sd2, odd: 4'd3,  by3: 1'b0, by5: 1'b0};
      5'd17:   c = '{off:  4'sd2, odd: 4'd1,  by3: 1'b0, by5: 1'b1};
      5'd18:   c = '{off: -4'sd1, odd: 4'd5,  by3: 1'b1, by5: 1'b0};
      5'd19:   c = '{off: -4'sd4, odd: 4'd9,  by3: 1'b0, by5: 1'b0};
      5'd20:   c = '{off: -4'sd4, odd: 4'd11, by3: 1'b0, by5: 1'b0};
      5'd21:   c = '{off: -4'sd4, odd: 4'd13, by3: 1'b0, by5: 1'b0};
      5'd22:   c = '{off: -4'sd3, odd: 4'd7,  by3: 1'b0, by5: 1'b0};
      5'd23:   c = '{off: -4'sd4, odd: 4'd15, by3: 1'b0, by5: 1'b0};
      default: c = '{off:  4'sd0, odd: 4'd1,  by3: 1'b0, by5: 1'b0};
    endcase
    return c;
  endfunction

endpackage

>>> sv/jrq_ratio.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jrq_ratio
// Error ratio max/min of one candidate against the target, as a >= b.
// ----------------------------------------------------------------------------
module jrq_ratio #(
  parameter int FRACTION_BITS = jrq_pkg::FRACTION_BITS_DEF,
  parameter int INTEGER_BITS  = jrq_pkg::INTEGER_BITS_DEF,
  localparam int TW = FRACTION_BITS + INTEGER_BITS,
  localparam int VW = TW + 8,
  localparam int EW = $clog2(TW + 8) + 2
) (
  input  wire logic [TW-1:0]               t,
  input  wire logic signed [EW-1:0]        e,
  input  wire logic [jrq_pkg::CIW-1:0]     idx,
  output logic [VW-1:0]                    a,
  output logic [VW-1:0]                    b
);

  jrq_pkg::cand_t    c;
  logic signed [EW-1:0] k;
  logic signed [EW-1:0] kn;
  logic [3:0]        d35;
  logic [VW-1:0]     num;
  logic [VW-1:0]     den;

  // Scale candidate and target to a common fixed point, then order them
  always_comb begin
    c   = jrq_pkg::cand_lookup(idx);
    k   = e + EW'(c.off) + EW'(FRACTION_BITS);
    kn  = -k;
    d35 = (c.by3 ? 4'd3 : 4'd1) * (c.by5 ? 4'd5 : 4'd1);
    num = VW'(c.odd);
    den = VW'(t) * VW'(d35);
    if (k > 0) begin
      num = num << k[EW-2:0];
    end
    if (k < 0) begin
      den = den << kn[EW-2:0];
    end
    if (num >= den) begin
      a = num;
      b = den;
    end else begin
      a = den;
      b = num;
    end
  end

endmodule
`default_nettype wire

>>> sv/jrq_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jrq_front
// Octave estimate of the target and error ratios of the first two candidates.
// ----------------------------------------------------------------------------
module jrq_front #(
  parameter int FRACTION_BITS = jrq_pkg::FRACTION_BITS_DEF,
  parameter int INTEGER_BITS  = jrq_pkg::INTEGER_BITS_DEF,
  localparam int TW = FRACTION_BITS + INTEGER_BITS,
  localparam int VW = TW + 8,
  localparam int EW = $clog2(TW + 8) + 2
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic [TW-1:0]        target,
  output jrq_pkg::ctl_t             ctl,
  output logic [TW-1:0]             t,
  output logic signed [EW-1:0]      e,
  output logic [VW-1:0]             ba,
  output logic [VW-1:0]             bb,
  output logic [VW-1:0]             ca,
  output logic [VW-1:0]             cb
);

  jrq_pkg::ctl_t        ctl1;
  logic [TW-1:0]        t1;
  logic signed [EW-1:0] e1;
  logic signed [EW-1:0] e_next;
  logic [VW-1:0]        a0, b0, a1, b1;

  // Leading one position, with truncation toward zero below one
  always_comb begin
    e_next = '0;
    for (int i = 0; i < TW; i++) begin
      if (target[i]) begin
        e_next = EW'(i);
      end
    end
    e_next = e_next - EW'(FRACTION_BITS);
    if ((target[TW-1:FRACTION_BITS] == '0) && ((target & (target - 1'b1)) != '0)) begin
      e_next = e_next + EW'(1);
    end
  end

  // Stage one: octave
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
    end else begin
      ctl1.valid <= in_valid;
      ctl1.zero  <= (target == '0);
    end
    t1 <= target;
    e1 <= e_next;
  end

  jrq_ratio #(.FRACTION_BITS(FRACTION_BITS), .INTEGER_BITS(INTEGER_BITS)) u_r0 (
    .t(t1), .e(e1), .idx(jrq_pkg::CIW'(0)), .a(a0), .b(b0)
  );

  jrq_ratio #(.FRACTION_BITS(FRACTION_BITS), .INTEGER_BITS(INTEGER_BITS)) u_r1 (
    .t(t1), .e(e1), .idx(jrq_pkg::CIW'(1)), .a(a1), .b(b1)
  );

  // Stage two: seed the winner with the first candidate
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl <= ctl1;
    end
    t  <= t1;
    e  <= e1;
    ba <= a0;
    bb <= b0;
    ca <= a1;
    cb <= b1;
  end

endmodule
`default_nettype wire

>>> sv/jrq_cmp_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jrq_cmp_stage
// One candidate: cross-multiply against the winner, then keep the better one.
// ----------------------------------------------------------------------------
module jrq_cmp_stage #(
  parameter int FRACTION_BITS = jrq_pkg::FRACTION_BITS_DEF,
  parameter int INTEGER_BITS  = jrq_pkg::INTEGER_BITS_DEF,
  parameter int IDX           = 1,
  localparam int TW = FRACTION_BITS + INTEGER_BITS,
  localparam int VW = TW + 8,
  localparam int EW = $clog2(TW + 8) + 2,
  localparam int PW = 2 * VW
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire jrq_pkg::ctl_t            ctl_in,
  input  wire logic [TW-1:0]            t_in,
  input  wire logic signed [EW-1:0]     e_in,
  input  wire logic [jrq_pkg::CIW-1:0]  best_in,
  input  wire logic [VW-1:0]            ba_in,
  input  wire logic [VW-1:0]            bb_in,
  input  wire logic [VW-1:0]            ca_in,
  input  wire logic [VW-1:0]            cb_in,
  output jrq_pkg::ctl_t                 ctl,
  output logic [TW-1:0]                 t,
  output logic signed [EW-1:0]          e,
  output logic [jrq_pkg::CIW-1:0]       best,
  output logic [VW-1:0]                 ba,
  output logic [VW-1:0]                 bb,
  output logic [VW-1:0]                 ca,
  output logic [VW-1:0]                 cb
);

  jrq_pkg::ctl_t                ctl_m;
  logic [TW-1:0]                t_m;
  logic signed [EW-1:0]         e_m;
  logic [jrq_pkg::CIW-1:0]      best_m;
  logic [VW-1:0]                ba_m, bb_m, ca_m, cb_m;
  logic [PW-1:0]                pa, pc;
  logic [VW-1:0]                na, nb;

  // Multiply stage: winner error against candidate error
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_m <= '0;
    end else begin
      ctl_m <= ctl_in;
    end
    t_m    <= t_in;
    e_m    <= e_in;
    best_m <= best_in;
    ba_m   <= ba_in;
    bb_m   <= bb_in;
    ca_m   <= ca_in;
    cb_m   <= cb_in;
    pa     <= PW'(ba_in) * PW'(cb_in);
    pc     <= PW'(ca_in) * PW'(bb_in);
  end

  // Prepare the next candidate alongside the compare
  if (IDX < jrq_pkg::NUM_CAND - 1) begin : g_next
    jrq_ratio #(.FRACTION_BITS(FRACTION_BITS), .INTEGER_BITS(INTEGER_BITS)) u_rn (
      .t(t_m), .e(e_m), .idx(jrq_pkg::CIW'(IDX + 1)), .a(na), .b(nb)
    );
  end else begin : g_last
    assign na = '0;
    assign nb = '0;
  end

  // Compare stage: the candidate wins unless the winner is strictly better
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl <= ctl_m;
    end
    t  <= t_m;
    e  <= e_m;
    ca <= na;
    cb <= nb;
    if (pa < pc) begin
      best <= best_m;
      ba   <= ba_m;
      bb   <= bb_m;
    end else begin
      best <= jrq_pkg::CIW'(IDX);
      ba   <= ca_m;
      bb   <= cb_m;
    end
  end

endmodule
`default_nettype wire

>>> sv/jrq_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jrq_back
// Form the result fields of the chosen candidate and register them.
// ----------------------------------------------------------------------------
module jrq_back #(
  parameter int FRACTION_BITS = jrq_pkg::FRACTION_BITS_DEF,
  parameter int INTEGER_BITS  = jrq_pkg::INTEGER_BITS_DEF,
  localparam int TW = FRACTION_BITS + INTEGER_BITS,
  localparam int EW = $clog2(TW + 8) + 2,
  localparam int NW = jrq_pkg::NUM_OUT_W + 4,
  localparam int DW = FRACTION_BITS + 12
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire jrq_pkg::ctl_t                    ctl_in,
  input  wire logic signed [EW-1:0]             e_in,
  input  wire logic [jrq_pkg::CIW-1:0]          best_in,
  output logic                                  done,
  output logic                                  valid_res,
  output logic signed [jrq_pkg::EXP_OUT_W-1:0]  octave_exponent,
  output logic [3:0]                            odd_factor,
  output logic                                  divide_by_three,
  output logic                                  divide_by_five,
  output logic [jrq_pkg::NUM_OUT_W-1:0]         ratio_numerator,
  output logic [jrq_pkg::DEN_OUT_W-1:0]         ratio_denominator
);

  jrq_pkg::cand_t       c;
  logic signed [EW-1:0] bits;
  logic signed [EW-1:0] nbits;
  logic [NW-1:0]        num;
  logic [DW-1:0]        den;

  // Numerator and denominator from the exponent and factor flags
  always_comb begin
    c     = jrq_pkg::cand_lookup(best_in);
    bits  = e_in + EW'(c.off);
    nbits = -bits;
    num   = NW'(c.odd);
    den   = DW'(1);
    if (bits > 0) begin
      num = num << bits[EW-2:0];
    end
    if (bits < 0) begin
      den = den << nbits[EW-2:0];
    end
    if (c.by3) begin
      den = den * DW'(3);
    end
    if (c.by5) begin
      den = den * DW'(5);
    end
  end

  // Hold the result beat; zero target clears every field
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_in.valid;
    end
    if (ctl_in.zero) begin
      valid_res         <= 1'b0;
      octave_exponent   <= '0;
      odd_factor        <= '0;
      divide_by_three   <= 1'b0;
      divide_by_five    <= 1'b0;
      ratio_numerator   <= '0;
      ratio_denominator <= '0;
    end else begin
      valid_res         <= 1'b1;
      octave_exponent   <= bits[jrq_pkg::EXP_OUT_W-1:0];
      odd_factor        <= c.odd;
      divide_by_three   <= c.by3;
      divide_by_five    <= c.by5;
      ratio_numerator   <= num[jrq_pkg::NUM_OUT_W-1:0];
      ratio_denominator <= den[jrq_pkg::DEN_OUT_W-1:0];
    end
  end

endmodule
`default_nettype wire

>>> sv/just_ratio_quantizer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// just_ratio_quantizer
// Nearest simple just-intonation ratio to a fixed-point frequency ratio.
// ----------------------------------------------------------------------------
// Usage:
//   Drive target_ratio (unsigned, INTEGER_BITS.FRACTION_BITS fixed point)
//   and pulse start. busy never rises, so a beat is taken on every cycle
//   start is high: one beat per cycle sustained.
//   Each beat returns one result, shown for a single cycle with done high:
//   valid_res, octave_exponent, odd_factor, divide_by_three, divide_by_five,
//   ratio_numerator, ratio_denominator. A zero target gives valid_res low
//   and all fields zero.
//   The beat passes 49 register stages, the first loaded by the start edge
//   itself: two for the octave estimate and the first candidates, two per
//   remaining candidate (a cross-multiply stage, then a compare stage; 23
//   of them) and one output register, which raises done with the result.
//   Reset clears all valid bits in flight; no result appears for beats
//   taken before reset. The receiver cannot hold results off, and no
//   result is ever dropped or repeated.
// ----------------------------------------------------------------------------
module just_ratio_quantizer #(
  parameter int FRACTION_BITS = jrq_pkg::FRACTION_BITS_DEF,
  parameter int INTEGER_BITS  = jrq_pkg::INTEGER_BITS_DEF,
  localparam int TW = FRACTION_BITS + INTEGER_BITS,
  localparam int VW = TW + 8,
  localparam int EW = $clog2(TW + 8) + 2
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [TW-1:0]                    target_ratio,
  output logic                                  done,
  output logic                                  valid_res,
  output logic signed [jrq_pkg::EXP_OUT_W-1:0]  octave_exponent,
  output logic [3:0]                            odd_factor,
  output logic                                  divide_by_three,
  output logic                                  divide_by_five,
  output logic [jrq_pkg::NUM_OUT_W-1:0]         ratio_numerator,
  output logic [jrq_pkg::DEN_OUT_W-1:0]         ratio_denominator
);

  localparam int NC = jrq_pkg::NUM_CAND;

  jrq_pkg::ctl_t              ctl_s  [NC];
  logic [TW-1:0]              t_s    [NC];
  logic signed [EW-1:0]       e_s    [NC];
  logic [jrq_pkg::CIW-1:0]    best_s [NC];
  logic [VW-1:0]              ba_s   [NC];
  logic [VW-1:0]              bb_s   [NC];
  logic [VW-1:0]              ca_s   [NC];
  logic [VW-1:0]              cb_s   [NC];

  // Fully pipelined: never refuse a beat
  assign busy      = 1'b0;
  assign best_s[0] = '0;

  jrq_front #(.FRACTION_BITS(FRACTION_BITS), .INTEGER_BITS(INTEGER_BITS)) u_front (
    .clk(clk), .rst(rst), .in_valid(start), .target(target_ratio),
    .ctl(ctl_s[0]), .t(t_s[0]), .e(e_s[0]),
    .ba(ba_s[0]), .bb(bb_s[0]), .ca(ca_s[0]), .cb(cb_s[0])
  );

  // Candidate chain in table order
  for (genvar i = 1; i < NC; i++) begin : g_cand
    jrq_cmp_stage #(
      .FRACTION_BITS(FRACTION_BITS), .INTEGER_BITS(INTEGER_BITS), .IDX(i)
    ) u_stage (
      .clk(clk), .rst(rst),
      .ctl_in(ctl_s[i-1]), .t_in(t_s[i-1]), .e_in(e_s[i-1]),
      .best_in(best_s[i-1]), .ba_in(ba_s[i-1]), .bb_in(bb_s[i-1]),
      .ca_in(ca_s[i-1]), .cb_in(cb_s[i-1]),
      .ctl(ctl_s[i]), .t(t_s[i]), .e(e_s[i]), .best(best_s[i]),
      .ba(ba_s[i]), .bb(bb_s[i]), .ca(ca_s[i]), .cb(cb_s[i])
    );
  end

  jrq_back #(.FRACTION_BITS(FRACTION_BITS), .INTEGER_BITS(INTEGER_BITS)) u_back (
    .clk(clk), .rst(rst),
    .ctl_in(ctl_s[NC-1]), .e_in(e_s[NC-1]), .best_in(best_s[NC-1]),
    .done(done), .valid_res(valid_res), .octave_exponent(octave_exponent),
    .odd_factor(odd_factor), .divide_by_three(divide_by_three),
    .divide_by_five(divide_by_five), .ratio_numerator(ratio_numerator),
    .ratio_denominator(ratio_denominator)
  );

endmodule
`default_nettype wire

>>> tb/just_ratio_quantizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// just_ratio_quantizer_tb
// Drives fixed-point targets into the quantizer, predicts the nearest just
// ratio with an exact integer search, and checks every result beat in order.
// ----------------------------------------------------------------------------
module just_ratio_quantizer_tb;

  localparam int FB = 16;
  localparam int IB = 8;
  localparam int TW = FB + IB;
  localparam int LATENCY = 49;

  typedef struct packed {
    logic                 ok;
    logic signed [5:0]    expo;
    logic [3:0]           odd;
    logic                 by3;
    logic                 by5;
    logic [13:0]          num;
    logic [23:0]          den;
  } ratio_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [TW-1:0] target_ratio = '0;
  logic busy, done, valid_res, divide_by_three, divide_by_five;
  logic signed [5:0] octave_exponent;
  logic [3:0] odd_factor;
  logic [13:0] ratio_numerator;
  logic [23:0] ratio_denominator;

  ratio_t pending_ratios[$];
  int mismatches = 0;
  int idle_pct = 0;

  just_ratio_quantizer u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .target_ratio(target_ratio), .done(done), .valid_res(valid_res),
    .octave_exponent(octave_exponent), .odd_factor(odd_factor),
    .divide_by_three(divide_by_three), .divide_by_five(divide_by_five),
    .ratio_numerator(ratio_numerator), .ratio_denominator(ratio_denominator)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Candidate ratios: octave offset, odd factor, divide-by-3 and by-5 flags
  function automatic void ratio_cand(input int i, output int off, output int odd,
                                     output bit by3, output bit by5);
    int offs[24] = '{0,-1,2,0,-2,1,3,-2,0,0,-1,-1,1,0,-3,1,-2,2,-1,-4,-4,-4,-3,-4};
    int odds[24] = '{1,3,1,5,5,3,1,7,7,9,7,11,1,3,5,1,3,1,5,9,11,13,7,15};
    bit b3s[24]  = '{0,0,1,1,0,0,0,0,0,0,1,1,0,0,0,1,0,0,1,0,0,0,0,0};
    bit b5s[24]  = '{0,0,0,0,0,1,1,0,1,1,0,0,0,1,0,0,0,1,0,0,0,0,0,0};
    off = offs[i]; odd = odds[i]; by3 = b3s[i]; by5 = b5s[i];
  endfunction

  // Error of one candidate as a/b with a >= b
  function automatic void cand_error(input int i, input int e, input logic [127:0] t,
                                     output logic [127:0] a, output logic [127:0] b);
    int off, odd, k;
    bit by3, by5;
    logic [127:0] n, d;
    ratio_cand(i, off, odd, by3, by5);
    k = e + off + FB;
    n = 128'(odd);
    d = t * 128'(by3 ? 3 : 1) * 128'(by5 ? 5 : 1);
    if (k > 0) n = n << k;
    if (k < 0) d = d << (-k);
    if (n >= d) begin a = n; b = d; end
    else begin a = d; b = n; end
  endfunction

  function automatic ratio_t nearest_ratio(input logic [TW-1:0] tin);
    ratio_t r;
    logic [127:0] t, ba, bb, ca, cb, num, den;
    int p, e, best, bits, off, odd;
    bit by3, by5;
    r = '0;
    t = 128'(tin);
    if (t == 0) return r;
    p = 0;
    while (p < 63 && (t >> (p + 1)) != 0) p++;
    e = p - FB;
    if (t < (128'd1 << FB) && (t & (t - 1)) != 0) e += 1;
    best = 0;
    cand_error(0, e, t, ba, bb);
    for (int i = 1; i < 24; i++) begin
      cand_error(i, e, t, ca, cb);
      // Later candidate wins unless current error is strictly smaller
      if (!(ba * cb < ca * bb)) begin
        best = i; ba = ca; bb = cb;
      end
    end
    ratio_cand(best, off, odd, by3, by5);
    bits = e + off;
    num = 128'(odd);
    if (bits > 0) num = num << bits;
    den = 128'd1;
    if (bits < 0) den = den << (-bits);
    if (by3) den = den * 3;
    if (by5) den = den * 5;
    r.ok = 1'b1; r.expo = bits[5:0]; r.odd = odd[3:0];
    r.by3 = by3; r.by5 = by5; r.num = num[13:0]; r.den = den[23:0];
    return r;
  endfunction

  // Send one beat, with a random hold-off per the idle setting
  task automatic send_target(input logic [TW-1:0] v);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    target_ratio <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_ratios.push_back(nearest_ratio(v));
  endtask

  task automatic stop_sending();
    start <= 1'b0;
    target_ratio <= TW'($urandom);
  endtask

  task automatic drain();
    stop_sending();
    while (pending_ratios.size() != 0) @(posedge clk);
  endtask

  // Check each result beat against the oldest expectation
  always @(posedge clk) begin
    ratio_t got, want;
    if (!rst && done) begin
      got = '{valid_res, octave_exponent, odd_factor, divide_by_three,
              divide_by_five, ratio_numerator, ratio_denominator};
      if (pending_ratios.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
      end else begin
        want = pending_ratios.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp ok=%0d e=%0d odd=%0d b3=%0d b5=%0d n=%0d d=%0d",
                     want.ok, want.expo, want.odd, want.by3, want.by5, want.num,
                     want.den, "  act ok=%0d e=%0d odd=%0d b3=%0d b5=%0d n=%0d d=%0d",
                     got.ok, got.expo, got.odd, got.by3, got.by5, got.num, got.den);
        end
      end
    end
  end

  // Extremes, zero, powers of two and exact candidate ratios
  task automatic test_directed();
    logic [TW-1:0] cases[] = '{24'h0, 24'h1, 24'h2, 24'h3, 24'hFFFFFF,
      24'h010000, 24'h008000, 24'h004000, 24'h000100, 24'h800000,
      24'h018000, 24'h015555, 24'h01AAAB, 24'h014000, 24'h01C000,
      24'h00C000, 24'h00AAAB, 24'h00E000, 24'h00F000, 24'h555555,
      24'hAAAAAA, 24'h7FFFFF, 24'h00FFFF, 24'h010001};
    idle_pct = 0;
    foreach (cases[i]) send_target(cases[i]);
    drain();
  endtask

  // Random targets spread over every octave, with assorted idle rates
  task automatic test_random(input int n, input int pct);
    logic [TW-1:0] v;
    int sh;
    idle_pct = pct;
    for (int i = 0; i < n; i++) begin
      sh = int'($urandom_range(TW - 1));
      v = TW'($urandom);
      if ($urandom_range(3) != 0) v = v >> sh;
      send_target(v);
    end
    stop_sending();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(400, 0);
    test_random(350, 51);
    drain();
    test_random(350, 16);
    test_random(350, 0);
    drain();
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && pending_ratios.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
